@@ src/tetbary_pkg.sv @@
package tetbary_pkg;

  localparam int COORD_WIDTH_DEF      = 16;
  localparam int WEIGHT_FRAC_BITS_DEF = 14;

  // fixed output weight width, signed
  localparam int WEIGHT_WIDTH = 18;

  // number of clocked stages from an accepted start to the done strobe
  localparam int PIPE_LATENCY = 8 + WEIGHT_WIDTH;

endpackage

@@ src/tetrahedron_barycentric_top.sv @@
// Tetrahedron barycentric weights. Each transaction takes four vertices and a query point
// (three signed coordinates each, x in the low bits) and returns four signed Q3.14 weights,
// rounded half away from zero and saturated, plus a degenerate flag that is set, with all
// weights zero, when the tetrahedron has zero volume. The block is a fixed pipeline: a new
// transaction may start in every clock cycle while busy is low, and busy is high only in the
// cycle after a reset cycle. Each result passes through the seven arithmetic stages
// (differences, cross partial products, cross components, triple product terms, sums, sign
// handling, range check), then one restoring-division stage per output weight bit, then the
// output register. The receiver cannot stall the block: every result is shown for one cycle
// only, and must be taken then.
module tetrahedron_barycentric_top import tetbary_pkg::*; #(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [3*COORD_WIDTH-1:0]         vertex_a,
  input  logic [3*COORD_WIDTH-1:0]         vertex_b,
  input  logic [3*COORD_WIDTH-1:0]         vertex_c,
  input  logic [3*COORD_WIDTH-1:0]         vertex_d,
  input  logic [3*COORD_WIDTH-1:0]         query_point,
  output logic                             done,
  output logic signed [WEIGHT_WIDTH-1:0]   weight_a,
  output logic signed [WEIGHT_WIDTH-1:0]   weight_b,
  output logic signed [WEIGHT_WIDTH-1:0]   weight_c,
  output logic signed [WEIGHT_WIDTH-1:0]   weight_d,
  output logic                             degenerate
);

  localparam int C  = COORD_WIDTH;
  localparam int F  = WEIGHT_FRAC_BITS;
  localparam int QW = WEIGHT_WIDTH;
  localparam int DW = C + 1;          // coordinate difference
  localparam int PW = 2 * C + 2;      // product of two differences
  localparam int XW = 2 * C + 3;      // cross product component
  localparam int TW = 3 * C + 6;      // triple product sum
  localparam int RW = TW + QW + F + 2; // division datapath

  // difference vector slots
  localparam int V_AP = 0;
  localparam int V_BP = 1;
  localparam int V_AB = 2;
  localparam int V_AC = 3;
  localparam int V_AD = 4;
  localparam int V_BC = 5;
  localparam int V_BD = 6;

  // crosses: bd x bc, ac x ad, ad x ab, ab x ac
  localparam int XV [4] = '{V_BD, V_AC, V_AD, V_AB};
  localparam int XR [4] = '{V_BC, V_AD, V_AB, V_AC};
  // triples: four sub-volumes, then the total volume
  localparam int TU [5] = '{V_BP, V_AP, V_AP, V_AP, V_AB};
  localparam int TX [5] = '{0, 1, 2, 3, 1};
  localparam int T_TOT = 4;

  localparam logic [QW-1:0] W_POS_SAT = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] W_NEG_SAT = {1'b1, {(QW-1){1'b0}}};

  logic accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // valid bits: diff, prod, cross, tprod, sum, sign, range check
  logic [6:0] vld;
  logic [QW-1:0] dvld;

  // stage 1: unpack, differences
  logic [3*C-1:0] pts [5];
  logic signed [C-1:0] crd [5][3];
  logic signed [DW-1:0] dv [7][3];

  assign pts[0] = vertex_a;
  assign pts[1] = vertex_b;
  assign pts[2] = vertex_c;
  assign pts[3] = vertex_d;
  assign pts[4] = query_point;

  always_comb begin
    for (int p = 0; p < 5; p++) begin
      for (int k = 0; k < 3; k++) begin
        crd[p][k] = pts[p][k*C +: C];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dv[V_AP][k] <= DW'(crd[4][k]) - DW'(crd[0][k]);
      dv[V_BP][k] <= DW'(crd[4][k]) - DW'(crd[1][k]);
      dv[V_AB][k] <= DW'(crd[1][k]) - DW'(crd[0][k]);
      dv[V_AC][k] <= DW'(crd[2][k]) - DW'(crd[0][k]);
      dv[V_AD][k] <= DW'(crd[3][k]) - DW'(crd[0][k]);
      dv[V_BC][k] <= DW'(crd[2][k]) - DW'(crd[1][k]);
      dv[V_BD][k] <= DW'(crd[3][k]) - DW'(crd[1][k]);
    end
  end

  // stage 2: cross product partial products, carry dot operands
  logic signed [PW-1:0] pr [4][3][2];
  logic signed [DW-1:0] ud2 [5][3];

  always_ff @(posedge clk) begin
    for (int x = 0; x < 4; x++) begin
      for (int k = 0; k < 3; k++) begin
        pr[x][k][0] <= PW'(dv[XV[x]][(k+1)%3]) * PW'(dv[XR[x]][(k+2)%3]);
        pr[x][k][1] <= PW'(dv[XV[x]][(k+2)%3]) * PW'(dv[XR[x]][(k+1)%3]);
      end
    end
    for (int t = 0; t < 5; t++) begin
      for (int k = 0; k < 3; k++) begin
        ud2[t][k] <= dv[TU[t]][k];
      end
    end
  end

  // stage 3: cross components
  logic signed [XW-1:0] cr [4][3];
  logic signed [DW-1:0] ud3 [5][3];

  always_ff @(posedge clk) begin
    for (int x = 0; x < 4; x++) begin
      for (int k = 0; k < 3; k++) begin
        cr[x][k] <= XW'(pr[x][k][0]) - XW'(pr[x][k][1]);
      end
    end
    ud3 <= ud2;
  end

  // stage 4: triple product terms
  logic signed [TW-1:0] tp [5][3];

  always_ff @(posedge clk) begin
    for (int t = 0; t < 5; t++) begin
      for (int k = 0; k < 3; k++) begin
        tp[t][k] <= TW'(ud3[t][k]) * TW'(cr[TX[t]][k]);
      end
    end
  end

  // stage 5: triple product sums
  logic signed [TW-1:0] ts [5];

  always_ff @(posedge clk) begin
    for (int t = 0; t < 5; t++) begin
      ts[t] <= tp[t][0] + tp[t][1] + tp[t][2];
    end
  end

  // stage 6: magnitudes, rounding offset, result signs
  logic [TW-1:0] tmag;
  logic [TW-1:0] smag [4];
  logic [RW-1:0] num6 [4];
  logic [RW-1:0] den6;
  logic          neg6 [4];
  logic          dgn6;

  always_comb begin
    tmag = ts[T_TOT][TW-1] ? TW'(-ts[T_TOT]) : TW'(ts[T_TOT]);
    for (int j = 0; j < 4; j++) begin
      smag[j] = ts[j][TW-1] ? TW'(-ts[j]) : TW'(ts[j]);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      num6[j] <= (RW'(smag[j]) << (F + 1)) + RW'(tmag);
      neg6[j] <= ts[j][TW-1] ^ ts[T_TOT][TW-1];
    end
    den6 <= RW'(tmag);
    dgn6 <= (ts[T_TOT] == '0);
  end

  // stage 7: range check, then one restoring division step per quotient bit
  logic [RW-1:0] rem  [QW+1][4];
  logic [QW-1:0] qacc [QW+1][4];
  logic          ovf  [QW+1][4];
  logic          ngs  [QW+1][4];
  logic [RW-1:0] den  [QW+1];
  logic          dgn  [QW+1];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      rem[0][j]  <= num6[j];
      qacc[0][j] <= '0;
      ovf[0][j]  <= num6[j] >= (den6 << (QW + 1));
      ngs[0][j]  <= neg6[j];
    end
    den[0] <= den6;
    dgn[0] <= dgn6;
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    logic [RW-1:0] dsh;
    logic          fit [4];

    assign dsh = den[s] << (QW - s);

    always_comb begin
      for (int j = 0; j < 4; j++) begin
        fit[j] = rem[s][j] >= dsh;
      end
    end

    always_ff @(posedge clk) begin
      for (int j = 0; j < 4; j++) begin
        rem[s+1][j]  <= fit[j] ? rem[s][j] - dsh : rem[s][j];
        qacc[s+1][j] <= {qacc[s][j][QW-2:0], fit[j]};
        ovf[s+1][j]  <= ovf[s][j];
        ngs[s+1][j]  <= ngs[s][j];
      end
      den[s+1] <= den[s];
      dgn[s+1] <= dgn[s];
    end
  end

  // output stage: sign, saturation, degenerate override
  logic [QW-1:0] wsel [4];
  logic [QW-1:0] wout [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (dgn[QW]) begin
        wsel[j] = '0;
      end else if (ngs[QW][j]) begin
        wsel[j] = (ovf[QW][j] || qacc[QW][j][QW-1]) ? W_NEG_SAT : QW'(-qacc[QW][j]);
      end else begin
        wsel[j] = (ovf[QW][j] || qacc[QW][j][QW-1]) ? W_POS_SAT : qacc[QW][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    wout       <= wsel;
    degenerate <= dgn[QW];
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      dvld <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[5:0], accept};
      dvld <= {dvld[QW-2:0], vld[6]};
      done <= dvld[QW-1];
    end
  end

  assign weight_a = wout[0];
  assign weight_b = wout[1];
  assign weight_c = wout[2];
  assign weight_d = wout[3];

endmodule

@@ src/tetbary_chk.sv @@
module tetbary_chk import tetbary_pkg::*; (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic signed [WEIGHT_WIDTH-1:0] weight_a,
  input logic signed [WEIGHT_WIDTH-1:0] weight_b,
  input logic signed [WEIGHT_WIDTH-1:0] weight_c,
  input logic signed [WEIGHT_WIDTH-1:0] weight_d,
  input logic                           degenerate
);

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |->
      (weight_a == '0 && weight_b == '0 && weight_c == '0 && weight_d == '0))
    else $error("degenerate result with nonzero weight");

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, PIPE_LATENCY))
    else $error("result strobe without matching start");

  a_busy_reset: assert property (@(posedge clk)
    busy |-> $past(rst))
    else $error("busy outside reset recovery");

endmodule

bind tetrahedron_barycentric_top tetbary_chk u_tetbary_chk (.*);
